### design/pdd_pkg.sv
// Shared types, constants and helper functions of the palette dither unit.
`timescale 1ns / 1ps

package pdd_pkg;

    localparam int LW_W  = 11;   // width of the line width register
    localparam int ERR_W = 10;   // width of one stored channel error
    localparam int DIST_W = 18;  // squared distance over three channels

    typedef logic [7:0] chan_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgb_t;

    typedef struct packed {
        err_t blue;
        err_t green;
        err_t red;
    } err3_t;

    // Power-up palette; slots beyond the sixteenth read as black.
    function automatic rgb_t default_colour(input logic [7:0] idx);
        rgb_t c;
        case (idx)
            8'd0:    c = '{blue: 8'd110, green: 8'd91,  red: 8'd149};
            8'd1:    c = '{blue: 8'd137, green: 8'd116, red: 8'd176};
            8'd2:    c = '{blue: 8'd15,  green: 8'd11,  red: 8'd17};
            8'd3:    c = '{blue: 8'd69,  green: 8'd47,  red: 8'd63};
            8'd4:    c = '{blue: 8'd112, green: 8'd75,  red: 8'd93};
            8'd5:    c = '{blue: 8'd24,  green: 8'd62,  red: 8'd47};
            8'd6:    c = '{blue: 8'd55,  green: 8'd90,  red: 8'd76};
            8'd7:    c = '{blue: 8'd115, green: 8'd212, red: 8'd190};
            8'd8:    c = '{blue: 8'd87,  green: 8'd176, red: 8'd160};
            8'd9:    c = '{blue: 8'd87,  green: 8'd120, red: 8'd116};
            8'd10:   c = '{blue: 8'd225, green: 8'd246, red: 8'd245};
            8'd11:   c = '{blue: 8'd130, green: 8'd146, red: 8'd148};
            8'd12:   c = '{blue: 8'd180, green: 8'd195, red: 8'd200};
            8'd13:   c = '{blue: 8'd27,  green: 8'd32,  red: 8'd36};
            8'd14:   c = '{blue: 8'd45,  green: 8'd54,  red: 8'd87};
            8'd15:   c = '{blue: 8'd72,  green: 8'd72,  red: 8'd121};
            default: c = '0;
        endcase
        return c;
    endfunction

    // Saturate a sum to the stored error range.
    function automatic err_t sat10(input logic signed [11:0] v);
        err_t r;
        if (v < -12'sd512)
            r = -10'sd512;
        else if (v > 12'sd511)
            r = 10'sd511;
        else
            r = v[ERR_W-1:0];
        return r;
    endfunction

endpackage

### design/pdd_palette.sv
// Palette memory: one write port, one registered read port, power-up colours.
`timescale 1ns / 1ps

module pdd_palette #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [$clog2(ENTRIES)-1:0] waddr,
    input  pdd_pkg::rgb_t              wdata,
    input  logic [$clog2(ENTRIES)-1:0] raddr,
    output pdd_pkg::rgb_t              rdata
);

    pdd_pkg::rgb_t mem [ENTRIES];
    logic [ENTRIES-1:0] written_reg;
    pdd_pkg::rgb_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // unwritten slots return their power-up colour
        if (written_reg[raddr])
            rdata_reg <= mem[raddr];
        else
            rdata_reg <= pdd_pkg::default_colour(8'(raddr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (we)
        begin
            written_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/pdd_err_line.sv
// Error line memory: per-column channel errors, one write and one read port.
`timescale 1ns / 1ps

module pdd_err_line #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  pdd_pkg::err3_t           wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output pdd_pkg::err3_t           rdata
);

    pdd_pkg::err3_t mem [DEPTH];
    pdd_pkg::err3_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/palette_error_diffusion_dither_unit.sv
// Top level of the palette error-diffusion dither unit: control, search and diffusion.
`timescale 1ns / 1ps

// Pixels stream in raster order and each yields the index of the nearest palette
// colour after Floyd-Steinberg error diffusion; palette write items are taken in the
// idle state without leaving it and yield nothing. A pixel occupies the unit through the
// calculation, the nearest-colour search, the error writes (the left write only outside
// the first column of a row) and the result hand-over; the search steps through the
// palette memory one entry per cycle on its single read port. The below-row errors sit
// in a memory of MAX_LINE entries with one write and one read port; a frame_start pixel
// resets a fill mark instead of sweeping it, so no clearing pass is needed after reset
// or at frame start. The result waits in an output register, so the next item is taken while it is still unread.

module palette_error_diffusion_dither_unit #(
    parameter int MAX_LINE        = 1024,
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], entry[27:24]
    input  logic [1:0]  s_tuser,   // func[0], frame_start[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // palette_index[3:0]
    output logic        m_tlast,   // row_end
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int COL_W = $clog2(MAX_LINE);
    localparam int CNT_W = $clog2(MAX_LINE + 1);
    localparam int CMP_W = (CNT_W > pdd_pkg::LW_W) ? CNT_W : pdd_pkg::LW_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CALC    = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_WR_LEFT = 3'd3;
    localparam logic [2:0] S_WR_HERE = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [pdd_pkg::LW_W-1:0] line_width_reg;
    logic [COL_W-1:0] column_reg, column_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    pdd_pkg::err3_t ahead_reg, ahead_next;
    pdd_pkg::err3_t carry_reg, carry_next;
    pdd_pkg::err3_t prev_reg, prev_next;
    pdd_pkg::rgb_t pix_reg, pix_next;
    pdd_pkg::rgb_t cur_reg, cur_next;
    pdd_pkg::rgb_t best_rgb_reg, best_rgb_next;
    logic [COL_W-1:0] x_reg, x_next;
    logic last_reg, last_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [pdd_pkg::DIST_W-1:0] best_d_reg, best_d_next;
    logic out_valid_reg, out_valid_next;
    logic [3:0] out_idx_reg, out_idx_next;
    logic out_last_reg, out_last_next;

    logic accept;
    logic is_load;
    logic frame_start;
    logic [3:0] entry;
    logic [COL_W-1:0] x_sel;
    logic [CMP_W-1:0] lw_ext, w_eff, x_plus;
    logic [CNT_W-1:0] x_fill;
    logic line_ok;

    logic pal_we;
    logic [IDX_W-1:0] pal_waddr, pal_raddr;
    pdd_pkg::rgb_t pal_wdata, pal_rdata;

    logic line_we, line_re;
    logic [COL_W-1:0] line_waddr;
    pdd_pkg::err3_t line_wdata, line_rdata, line_eff;

    logic signed [8:0] e_r, e_g, e_b;
    logic signed [8:0] t_r, t_g, t_b;
    logic signed [17:0] sq_r, sq_g, sq_b;
    logic [pdd_pkg::DIST_W-1:0] sq_sum;
    pdd_pkg::err3_t f1, f3, f5, f7, here_val, left_val;

    function automatic pdd_pkg::chan_t clamp_pix(input pdd_pkg::chan_t p,
                                                 input pdd_pkg::err_t a,
                                                 input pdd_pkg::err_t b);
        logic signed [11:0] v;
        pdd_pkg::chan_t r;
        v = $signed({4'b0, p}) + 12'(a) + 12'(b);
        if (v < 12'sd0)
            r = 8'd0;
        else if (v > 12'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    // floor((e * w) / 16)
    function automatic pdd_pkg::err_t share(input logic signed [8:0] e,
                                            input logic [2:0] w);
        logic signed [12:0] p;
        p = 13'(e) * $signed({10'b0, w});
        return 10'(p >>> 4);
    endfunction

    assign is_load     = s_tuser[0];
    assign frame_start = s_tuser[1];
    assign entry       = s_tdata[27:24];
    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;

    assign x_sel  = frame_start ? '0 : column_reg;
    assign lw_ext = CMP_W'(line_width_reg);
    assign w_eff  = (lw_ext == '0) ? CMP_W'(1) :
                    (lw_ext > CMP_W'(MAX_LINE)) ? CMP_W'(MAX_LINE) : lw_ext;
    assign x_plus = CMP_W'(x_sel) + CMP_W'(1);
    assign x_fill = CNT_W'(x_reg) + CNT_W'(1);

    // columns at or past the fill mark were not written this frame
    assign line_ok  = (CNT_W'(x_reg) < fill_reg);
    assign line_eff = line_ok ? line_rdata : '0;

    assign pal_we    = accept && is_load && ({5'b0, entry} < 9'(PALETTE_ENTRIES));
    assign pal_waddr = IDX_W'({4'b0, entry});
    assign pal_wdata = '{blue: s_tdata[23:16], green: s_tdata[15:8], red: s_tdata[7:0]};
    assign pal_raddr = (state_reg == S_SEARCH) ? cnt_reg + IDX_W'(1) : '0;

    assign t_r  = $signed({1'b0, cur_reg.red})   - $signed({1'b0, pal_rdata.red});
    assign t_g  = $signed({1'b0, cur_reg.green}) - $signed({1'b0, pal_rdata.green});
    assign t_b  = $signed({1'b0, cur_reg.blue})  - $signed({1'b0, pal_rdata.blue});
    assign sq_r = t_r * t_r;
    assign sq_g = t_g * t_g;
    assign sq_b = t_b * t_b;
    assign sq_sum = $unsigned(sq_r) + $unsigned(sq_g) + $unsigned(sq_b);

    assign e_r = $signed({1'b0, cur_reg.red})   - $signed({1'b0, best_rgb_reg.red});
    assign e_g = $signed({1'b0, cur_reg.green}) - $signed({1'b0, best_rgb_reg.green});
    assign e_b = $signed({1'b0, cur_reg.blue})  - $signed({1'b0, best_rgb_reg.blue});

    assign f1 = '{blue: share(e_b, 3'd1), green: share(e_g, 3'd1), red: share(e_r, 3'd1)};
    assign f3 = '{blue: share(e_b, 3'd3), green: share(e_g, 3'd3), red: share(e_r, 3'd3)};
    assign f5 = '{blue: share(e_b, 3'd5), green: share(e_g, 3'd5), red: share(e_r, 3'd5)};
    assign f7 = '{blue: share(e_b, 3'd7), green: share(e_g, 3'd7), red: share(e_r, 3'd7)};

    assign here_val = '{
        blue:  pdd_pkg::sat10(12'(carry_reg.blue) + 12'(f5.blue)),
        green: pdd_pkg::sat10(12'(carry_reg.green) + 12'(f5.green)),
        red:   pdd_pkg::sat10(12'(carry_reg.red) + 12'(f5.red))
    };
    assign left_val = '{
        blue:  pdd_pkg::sat10(12'(prev_reg.blue) + 12'(f3.blue)),
        green: pdd_pkg::sat10(12'(prev_reg.green) + 12'(f3.green)),
        red:   pdd_pkg::sat10(12'(prev_reg.red) + 12'(f3.red))
    };

    assign line_re    = accept && !is_load;
    assign line_we    = (state_reg == S_WR_LEFT) || (state_reg == S_WR_HERE);
    assign line_waddr = (state_reg == S_WR_LEFT) ? x_reg - COL_W'(1) : x_reg;
    assign line_wdata = (state_reg == S_WR_LEFT) ? left_val : here_val;

    pdd_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    pdd_err_line #(
        .DEPTH (MAX_LINE)
    ) u_err_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (x_sel),
        .rdata (line_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        column_next    = column_reg;
        fill_next      = fill_reg;
        ahead_next     = ahead_reg;
        carry_next     = carry_reg;
        prev_next      = prev_reg;
        pix_next       = pix_reg;
        cur_next       = cur_reg;
        best_rgb_next  = best_rgb_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_load)
                begin
                    if (frame_start)
                    begin
                        column_next = '0;
                        fill_next   = '0;
                        ahead_next  = '0;
                        carry_next  = '0;
                    end
                    pix_next   = pal_wdata;
                    x_next     = x_sel;
                    last_next  = (x_plus >= w_eff);
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cur_next.red   = clamp_pix(pix_reg.red, line_eff.red, ahead_reg.red);
                cur_next.green = clamp_pix(pix_reg.green, line_eff.green, ahead_reg.green);
                cur_next.blue  = clamp_pix(pix_reg.blue, line_eff.blue, ahead_reg.blue);
                cnt_next       = '0;
                state_next     = S_SEARCH;
            end
            S_SEARCH:
            begin
                // strict compare keeps the lowest index on a tie
                if ((cnt_reg == '0) || (sq_sum < best_d_reg))
                begin
                    best_d_next   = sq_sum;
                    best_idx_next = cnt_reg;
                    best_rgb_next = pal_rdata;
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(PALETTE_ENTRIES - 1))
                begin
                    state_next = (x_reg != '0) ? S_WR_LEFT : S_WR_HERE;
                end
            end
            S_WR_LEFT:
            begin
                state_next = S_WR_HERE;
            end
            S_WR_HERE:
            begin
                prev_next = here_val;
                if (x_fill > fill_reg)
                    fill_next = x_fill;
                if (last_reg)
                begin
                    ahead_next  = '0;
                    carry_next  = '0;
                    column_next = '0;
                end
                else
                begin
                    ahead_next  = f7;
                    carry_next  = f1;
                    column_next = x_reg + COL_W'(1);
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = 4'(best_idx_reg);
                    out_last_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            line_width_reg <= pdd_pkg::LW_W'(1024);
            column_reg     <= '0;
            fill_reg       <= '0;
            ahead_reg      <= '0;
            carry_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            fill_reg      <= fill_next;
            ahead_reg     <= ahead_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                line_width_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        pix_reg      <= pix_next;
        cur_reg      <= cur_next;
        best_rgb_reg <= best_rgb_next;
        x_reg        <= x_next;
        last_reg     <= last_next;
        cnt_reg      <= cnt_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_idx_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0]) |=> !s_tready)
        else $error("unit ready right after taking a pixel item");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> s_tready)
        else $error("palette write item stalled the input");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_LINE))
        else $error("fill mark beyond the error line depth");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("finished pixel not presented on the output");
`endif

endmodule

### verif/tb_top.sv
// Self-checking bench for the palette error-diffusion dither unit: queue driver, monitor.
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic { OP_PIXEL = 1'b0, OP_LOAD = 1'b1 } op_e;

    typedef struct {
        op_e        op;
        logic [7:0] r, g, b;
        logic [3:0] slot;
        logic       fs;
    } pix_item_t;

    typedef struct {
        logic [3:0] idx;
        logic       row_end;
    } dither_out_t;

    localparam int LINE_MAX = 1024;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;

    palette_error_diffusion_dither_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    int          pal [16][3];
    int          err_row [LINE_MAX][3];
    int          err_right [3];
    int          err_carry [3];
    int          col_pos;
    int          width_reg;

    pix_item_t   pending [$];
    dither_out_t expected_idx [$];
    pix_item_t   cur_item;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          quiet = 1'b0;
    bit          took = 1'b0;
    bit          got = 1'b0;
    int          mismatches = 0;

    function automatic int sat_err(input int v);
        return (v < -512) ? -512 : ((v > 511) ? 511 : v);
    endfunction

    task automatic load_default_palette();
        int tbl [16][3] = '{
            '{149, 91, 110}, '{176, 116, 137}, '{17, 11, 15}, '{63, 47, 69},
            '{93, 75, 112}, '{47, 62, 24}, '{76, 90, 55}, '{190, 212, 115},
            '{160, 176, 87}, '{116, 120, 87}, '{245, 246, 225}, '{148, 146, 130},
            '{200, 195, 180}, '{36, 32, 27}, '{87, 54, 45}, '{121, 72, 72}};
        pal = tbl;
    endtask

    task automatic clear_error_store();
        for (int i = 0; i < LINE_MAX; i++)
            for (int c = 0; c < 3; c++)
                err_row[i][c] = 0;
        for (int c = 0; c < 3; c++)
        begin
            err_right[c] = 0;
            err_carry[c] = 0;
        end
        col_pos = 0;
    endtask

    task automatic dither_predict(input pix_item_t it);
        int w, x, best, best_d, d, t, e;
        int px [3];
        int cv [3];
        bit last;
        dither_out_t o;
        px[0] = int'(it.r); px[1] = int'(it.g); px[2] = int'(it.b);
        if (it.op == OP_LOAD)
        begin
            for (int c = 0; c < 3; c++)
                pal[it.slot][c] = px[c];
            return;
        end
        if (it.fs)
            clear_error_store();
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
        x = col_pos;
        last = (x + 1 >= w);
        for (int c = 0; c < 3; c++)
        begin
            cv[c] = px[c] + err_row[x][c] + err_right[c];
            if (cv[c] < 0) cv[c] = 0;
            if (cv[c] > 255) cv[c] = 255;
        end
        best = 0;
        best_d = 32'h7fffffff;
        for (int i = 0; i < 16; i++)
        begin
            d = 0;
            for (int c = 0; c < 3; c++)
            begin
                t = cv[c] - pal[i][c];
                d += t * t;
            end
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            e = cv[c] - pal[best][c];
            if (x > 0)
                err_row[x-1][c] = sat_err(err_row[x-1][c] + ((e * 3) >>> 4));
            err_row[x][c] = sat_err(err_carry[c] + ((e * 5) >>> 4));
            err_carry[c] = last ? 0 : (e >>> 4);
            err_right[c] = last ? 0 : ((e * 7) >>> 4);
        end
        col_pos = last ? 0 : x + 1;
        o.idx = best[3:0];
        o.row_end = last;
        expected_idx.push_back(o);
    endtask

    // accept side: predictor and config tracking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            width_reg = int'(cfg_wdata);
        if (rst_n && s_tvalid && s_tready)
        begin
            dither_predict(cur_item);
            took = 1'b1;
        end
    end

    // driver: present items at the falling edge
    always @(negedge clk)
    begin
        logic nv;
        nv = s_tvalid;
        if (took)
        begin
            took = 1'b0;
            nv = 1'b0;
            send_gap = quiet ? 0 : $urandom_range(0, 13);
        end
        if (!nv && rst_n)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending.size() > 0)
            begin
                cur_item = pending.pop_front();
                s_tdata <= {4'b0, cur_item.slot, cur_item.b, cur_item.g, cur_item.r};
                s_tuser <= {cur_item.fs, cur_item.op};
                nv = 1'b1;
            end
        end
        s_tvalid <= nv;
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = 1'b1;
            if (expected_idx.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d row_end=%0b", m_tdata[3:0], m_tlast);
            end
            else
            begin
                dither_out_t x;
                x = expected_idx.pop_front();
                if (m_tdata !== {4'b0, x.idx} || m_tlast !== x.row_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx=%0d row_end=%0b, got tdata=%0h row_end=%0b",
                                 x.idx, x.row_end, m_tdata, m_tlast);
                end
            end
        end
    end

    // receiver stalls, drawn per result
    always @(negedge clk)
    begin
        if (got)
        begin
            got = 1'b0;
            recv_gap = quiet ? 0 : $urandom_range(0, 13);
        end
        if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    task automatic push_item(input op_e op, input int r, input int g, input int b,
                             input int slot, input bit fs);
        pix_item_t it;
        it.op = op; it.r = r[7:0]; it.g = g[7:0]; it.b = b[7:0];
        it.slot = slot[3:0]; it.fs = fs;
        pending.push_back(it);
    endtask

    task automatic drain();
        wait (pending.size() == 0);
        @(posedge clk);
        wait (!s_tvalid);
        wait (expected_idx.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_width(input int v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int widths [10] = '{1024, 1, 3, 8, 0, 2047, 5, 2, 13, 1024};
        int n;
        load_default_palette();
        clear_error_store();
        width_reg = 1024;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, default palette, ties, frame start on a load
        push_item(OP_PIXEL, 0, 0, 0, 0, 1'b1);
        push_item(OP_PIXEL, 255, 255, 255, 15, 1'b0);
        push_item(OP_PIXEL, 255, 0, 255, 0, 1'b0);
        push_item(OP_LOAD, 255, 255, 255, 15, 1'b1);
        push_item(OP_PIXEL, 255, 255, 255, 0, 1'b0);
        push_item(OP_LOAD, 0, 0, 0, 0, 1'b0);
        push_item(OP_LOAD, 0, 0, 0, 1, 1'b0);
        push_item(OP_PIXEL, 0, 0, 0, 0, 1'b1);
        push_item(OP_PIXEL, 128, 128, 128, 0, 1'b0);
        push_item(OP_LOAD, 170, 85, 240, 10, 1'b1);
        push_item(OP_PIXEL, 170, 85, 240, 0, 1'b0);
        push_item(OP_PIXEL, 0, 255, 0, 0, 1'b0);
        push_item(OP_PIXEL, 255, 0, 0, 0, 1'b1);
        drain();

        // phases over several widths; width changes mid-row on purpose
        for (int p = 0; p < 10; p++)
        begin
            quiet = (p % 4 == 3);
            write_width(widths[p]);
            n = 55 + $urandom_range(0, 20);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 15),
                              1'($urandom_range(0, 1)));
                else
                    push_item(OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 15),
                              (k == 0 && p % 2 == 0) || $urandom_range(0, 40) == 0);
            end
            drain();
        end

        if (mismatches == 0 && expected_idx.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
